/* src/bfci_pkg.sv */
// Shared constants, types and a helper function for the correlation-immunity block.
package bfci_pkg;

  localparam int N_VARS      = 4;
  localparam int LEN         = 1 << N_VARS;
  localparam int HALF        = LEN / 2;
  localparam int SPEC_W      = N_VARS + 2;
  localparam int TT_W        = 16;
  localparam int EXT_W       = (LEN > TT_W) ? LEN : TT_W;
  localparam int CI_W        = 3;
  localparam int OUT_TDATA_W = 8;

  // Full spectrum word: one signed coefficient per mask, mask 0 lowest
  typedef logic [LEN-1:0][SPEC_W-1:0] spec_t;

  // Hamming weight of a mask index
  function automatic int mask_weight(input int m);
    int c;
    c = 0;
    for (int b = 0; b < N_VARS; b++) begin
      c = c + ((m >> b) & 1);
    end
    return c;
  endfunction

endpackage

/* src/bfci_bfly_stage.sv */
// One registered Walsh-Hadamard stage: a row of butterfly lanes in constant-geometry order.
module bfci_bfly_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  bfci_pkg::spec_t up_data,
  output logic           up_ready,
  input  logic           dn_ready,
  output logic           valid_r,
  output bfci_pkg::spec_t data_r
);
  import bfci_pkg::*;

  spec_t data_nxt;
  logic  valid_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Lane i pairs entries i and i + HALF, writes sum and difference side by side
  always_comb begin
    for (int i = 0; i < HALF; i++) begin
      data_nxt[2*i]   = SPEC_W'($signed(up_data[i]) + $signed(up_data[i+HALF]));
      data_nxt[2*i+1] = SPEC_W'($signed(up_data[i]) - $signed(up_data[i+HALF]));
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* src/bfci_merge.sv */
// Merge of lane results: weight-ordered scan of the spectrum, balance test, output register.
module bfci_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  input  bfci_pkg::spec_t                      up_data,
  output logic                                 up_ready,
  output logic                                 out_valid_r,
  input  logic                                 out_ready,
  output logic [bfci_pkg::OUT_TDATA_W-1:0]     out_data_r
);
  import bfci_pkg::*;

  logic [N_VARS:1]        wnz;
  logic                   found;
  logic [CI_W-1:0]        ci;
  logic                   bal;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic                   out_valid_nxt;

  assign up_ready = !out_valid_r || out_ready;

  // Flag every weight that owns a nonzero coefficient
  always_comb begin
    wnz = '0;
    for (int m = 1; m < LEN; m++) begin
      if (up_data[m] != '0) begin
        wnz[mask_weight(m)] = 1'b1;
      end
    end
  end

  // First flagged weight, lowest first
  always_comb begin
    found = 1'b0;
    ci    = '0;
    for (int k = 1; k <= N_VARS; k++) begin
      if (!found && wnz[k]) begin
        ci    = CI_W'(k - 1);
        found = 1'b1;
      end
    end
  end

  // Mask 0 holds the count of ones
  assign bal = (up_data[0] == SPEC_W'(HALF));

  assign out_data_nxt = OUT_TDATA_W'({(bal ? ci : {CI_W{1'b0}}), bal, ci});

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (up_ready) begin
      out_valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* src/boolean_function_ci_order.sv */
// Top level: correlation-immunity and resilience order of a Boolean function from its truth table.
// Pipeline: N_VARS butterfly stages plus one output register.
// Throughput: one transaction per cycle unless the output stalls (fully pipelined stages).
// Each stage holds its own valid bit, so bubbles are squeezed out while the output is stalled.
// Reset: synchronous, active low; clears every stage valid bit, payload registers keep contents.
// No internal state survives between transactions.
module boolean_function_ci_order (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata fields from bit 0 up: truth_table[15:0]
  input  logic [bfci_pkg::TT_W-1:0]        in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata fields from bit 0 up: ci_order[2:0], is_balanced[3], resilience_order[6:4], pad[7]
  output logic [bfci_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bfci_pkg::*;

  logic [EXT_W-1:0] tt_ext;
  spec_t            sdata  [N_VARS+1];
  logic [N_VARS:0]  svalid;
  logic [N_VARS:0]  sready;

  // Table entries beyond the input field read as zero; each entry enters as a 0/1 coefficient
  assign tt_ext = EXT_W'(in_tdata);

  always_comb begin
    for (int i = 0; i < LEN; i++) begin
      sdata[0][i] = SPEC_W'(tt_ext[i]);
    end
  end

  assign svalid[0] = in_tvalid;
  assign in_tready = sready[0];

  // Identical constant-geometry stages: after N_VARS of them the spectrum is in natural order
  for (genvar k = 0; k < N_VARS; k++) begin : g_stage
    bfci_bfly_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (svalid[k]),
      .up_data  (sdata[k]),
      .up_ready (sready[k]),
      .dn_ready (sready[k+1]),
      .valid_r  (svalid[k+1]),
      .data_r   (sdata[k+1])
    );
  end

  // Scan by weight, test balance and hold the result until the transaction completes
  bfci_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (svalid[N_VARS]),
    .up_data     (sdata[N_VARS]),
    .up_ready    (sready[N_VARS]),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_data_r  (out_tdata)
  );

`ifndef SYNTHESIS
  // Resilience order is the CI order of a balanced function and zero otherwise
  a_resilience: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] ? (out_tdata[6:4] == out_tdata[2:0]) : (out_tdata[6:4] == '0)))
    else $error("resilience order disagrees with balance flag");

  // CI order never reaches the variable count
  a_ci_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[2:0]) < N_VARS))
    else $error("ci_order out of range");

  // A completely full pipe behind a stalled output refuses new input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && (&svalid[N_VARS:1])) |-> !in_tready)
    else $error("input accepted into a full, stalled pipeline");

  // The last butterfly stage, when holding data under backpressure, still holds it
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (svalid[N_VARS] && !sready[N_VARS]) |=> svalid[N_VARS])
    else $error("last butterfly stage dropped a transaction");
`endif

endmodule

/* tb/tb_boolean_function_ci_order.sv */
// Self-checking testbench for the correlation-immunity order block of a Boolean function.
`timescale 1ns / 100ps

module tb_boolean_function_ci_order;
  import bfci_pkg::*;

  // Expected contents of one result transaction, laid out as on out_tdata
  typedef struct packed {
    logic [CI_W-1:0] resilience_order;
    logic            is_balanced;
    logic [CI_W-1:0] ci_order;
  } ci_result_t;

  // Shapes of truth table that the random stimulus draws from
  typedef enum int {
    TT_UNIFORM,
    TT_BALANCED,
    TT_AFFINE,
    TT_QUADRATIC
  } tt_shape_e;

  localparam int PIPE_DEPTH     = N_VARS + 1;
  localparam int SETTLE_CYCLES  = 4 * PIPE_DEPTH;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_RUN = 458;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [TT_W-1:0]        in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [TT_W-1:0] tables_to_send [$];   // truth tables still to be offered
  ci_result_t      orders_due     [$];   // predictions awaiting their result
  int              sender_idle_pct = 0;
  int              sink_stall_pct  = 0;
  int              error_count     = 0;
  int              quiet_cycles    = 0;

  boolean_function_ci_order dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Walsh spectrum of the 0/1 table, then scan masks by rising Hamming weight.
  // The first weight holding a nonzero coefficient sets the order; a function
  // whose spectrum is zero at every nonzero mask (a constant) keeps order 0.
  function automatic ci_result_t predict_ci_order(input logic [TT_W-1:0] tt);
    int         spec [LEN];
    int         ones;
    int         a;
    int         b;
    bit         found;
    ci_result_t r;
    ones  = 0;
    found = 1'b0;
    r     = '0;
    for (int i = 0; i < LEN; i++) begin
      // entries past the 16-bit table come from bits tied low
      spec[i] = (i < TT_W) ? int'(tt[i]) : 0;
      ones    = ones + spec[i];
    end
    for (int h = 1; h < LEN; h = h << 1) begin
      for (int base = 0; base < LEN; base = base + 2 * h) begin
        for (int j = 0; j < h; j++) begin
          a               = spec[base + j];
          b               = spec[base + j + h];
          spec[base + j]     = a + b;
          spec[base + j + h] = a - b;
        end
      end
    end
    for (int k = 1; k <= N_VARS; k++) begin
      for (int m = 1; m < LEN; m++) begin
        if (!found && $countones(m) == k && spec[m] != 0) begin
          r.ci_order = CI_W'(k - 1);
          found      = 1'b1;
        end
      end
    end
    r.is_balanced      = (ones == HALF);
    r.resilience_order = r.is_balanced ? r.ci_order : '0;
    return r;
  endfunction

  function automatic bit mask_parity(input int v, input int m);
    return ^(v & m);
  endfunction

  // Draw one truth table; structured shapes reach the high orders that a
  // uniform draw almost never hits.
  function automatic logic [TT_W-1:0] draw_table(input tt_shape_e shape);
    logic [TT_W-1:0] tt;
    int              m1;
    int              m2;
    int              m3;
    bit              flip;
    tt   = '0;
    m1   = $urandom_range(LEN - 1);
    m2   = $urandom_range(LEN - 1);
    m3   = $urandom_range(LEN - 1);
    flip = 1'($urandom_range(1));
    case (shape)
      TT_UNIFORM: begin
        tt = TT_W'($urandom);
      end
      TT_BALANCED: begin
        while ($countones(tt) < HALF) tt[$urandom_range(LEN - 1)] = 1'b1;
      end
      TT_AFFINE: begin
        for (int i = 0; i < LEN; i++) tt[i] = mask_parity(i, m1) ^ flip;
      end
      default: begin
        for (int i = 0; i < LEN; i++) begin
          tt[i] = mask_parity(i, m1) ^ (mask_parity(i, m2) & mask_parity(i, m3)) ^ flip;
        end
      end
    endcase
    return tt;
  endfunction

  // Driver: advance to the next queued table once the current transaction
  // has gone, idling at random; predict every table as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) orders_due.push_back(predict_ci_order(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (tables_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= tables_to_send.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction,
  // stalling the output at random.
  always @(posedge clk) begin
    ci_result_t want;
    ci_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = ci_result_t'(out_tdata[$bits(ci_result_t)-1:0]);
        if (orders_due.size() == 0) begin
          $error("result 0x%02h arrived with no table outstanding", out_tdata);
          error_count++;
        end else begin
          want = orders_due.pop_front();
          if (got.ci_order !== want.ci_order) begin
            $error("ci_order: expected %0d, got %0d", want.ci_order, got.ci_order);
            error_count++;
          end
          if (got.is_balanced !== want.is_balanced) begin
            $error("is_balanced: expected %0d, got %0d", want.is_balanced, got.is_balanced);
            error_count++;
          end
          if (got.resilience_order !== want.resilience_order) begin
            $error("resilience_order: expected %0d, got %0d",
                   want.resilience_order, got.resilience_order);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: count cycles in which neither side completes a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the caller until the queue, the input port and every prediction
  // have drained, so that the block is empty before the next phase.
  task automatic wait_for_drain();
    while (tables_to_send.size() > 0 || in_tvalid || orders_due.size() > 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    for (int n = 0; n < RANDOM_PER_RUN; n++) begin
      tables_to_send.push_back(draw_table(tt_shape_e'($urandom_range(3))));
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed tables: constants, single minterms, dictators, parity (the
    // highest order), balanced functions of each order and near-balanced ones.
    tables_to_send.push_back(16'h0000);  // constant zero: no nonzero coefficient
    tables_to_send.push_back(16'hFFFF);  // constant one
    tables_to_send.push_back(16'h0001);
    tables_to_send.push_back(16'h8000);
    tables_to_send.push_back(16'h7FFF);
    tables_to_send.push_back(16'hFFFE);
    tables_to_send.push_back(16'hAAAA);  // x0
    tables_to_send.push_back(16'h5555);  // not x0
    tables_to_send.push_back(16'hCCCC);  // x1
    tables_to_send.push_back(16'hF0F0);  // x2
    tables_to_send.push_back(16'hFF00);  // x3
    tables_to_send.push_back(16'h6666);  // x0 ^ x1
    tables_to_send.push_back(16'h9696);  // x0 ^ x1 ^ x2
    tables_to_send.push_back(16'h6996);  // full parity
    tables_to_send.push_back(16'h9669);  // full parity complemented
    tables_to_send.push_back(16'h6969);
    tables_to_send.push_back(16'h00FF);
    tables_to_send.push_back(16'h0F0F);
    tables_to_send.push_back(16'h3333);
    tables_to_send.push_back(16'h8888);  // x0 & x1: unbalanced
    tables_to_send.push_back(16'h1E1E);
    tables_to_send.push_back(16'h0101);
    tables_to_send.push_back(16'h00F0);
    wait_for_drain();

    // Random phases: free flow, sender idling, receiver stalling, then both.
    run_random_phase(0, 0);
    run_random_phase(69, 0);
    run_random_phase(0, 69);
    run_random_phase(32, 32);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && orders_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bfci_pkg.sv
src/bfci_bfly_stage.sv
src/bfci_merge.sv
src/boolean_function_ci_order.sv
tb/tb_boolean_function_ci_order.sv
